[hw/rtl/script_lexer_tokenizer_core_assert.svh]
// Assertion macros shared by the lexer RTL files.
// Define NO_ASSERTIONS to compile the checks away; no other dependencies.
`ifndef SCRIPT_LEXER_TOKENIZER_CORE_ASSERT_SVH
`define SCRIPT_LEXER_TOKENIZER_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Checks that cond holds in the same cycle as trig.
`define SLT_ASSERT_IMPL(label, clk, rst, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error("lexer assertion failed");
// Checks that cond holds in the cycle after trig.
`define SLT_ASSERT_NEXT(label, clk, rst, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("lexer assertion failed");
`else
`define SLT_ASSERT_IMPL(label, clk, rst, trig, cond)
`define SLT_ASSERT_NEXT(label, clk, rst, trig, cond)
`endif
`endif

[hw/rtl/slt_pkg.sv]
// Shared constants, token kinds and queue record types for the lexer.
// No dependencies.
`default_nettype none
package slt_pkg;

  localparam int KEYWORD_CHARS = 6;
  localparam int OFFSET_BITS   = 16;
  localparam int KW_BITS       = 8 * KEYWORD_CHARS;
  localparam int TOK_W         = 16;
  localparam int FIFO_DEPTH    = 4;
  localparam int FIFO_PTR_W    = $clog2(FIFO_DEPTH);
  localparam int OUT_DATA_W    = 40;

  typedef enum logic [4:0] {
    TK_ILLEGAL   = 5'd0,
    TK_EOF       = 5'd1,
    TK_IDENT     = 5'd2,
    TK_INT       = 5'd3,
    TK_ASSIGN    = 5'd4,
    TK_PLUS      = 5'd5,
    TK_MINUS     = 5'd6,
    TK_BANG      = 5'd7,
    TK_ASTERISK  = 5'd8,
    TK_SLASH     = 5'd9,
    TK_EQ        = 5'd10,
    TK_NOT_EQ    = 5'd11,
    TK_LT        = 5'd12,
    TK_GT        = 5'd13,
    TK_COMMA     = 5'd14,
    TK_SEMICOLON = 5'd15,
    TK_LPAREN    = 5'd16,
    TK_RPAREN    = 5'd17,
    TK_LBRACE    = 5'd18,
    TK_RBRACE    = 5'd19,
    TK_FN        = 5'd20,
    TK_LET       = 5'd21,
    TK_TRUE      = 5'd22,
    TK_FALSE     = 5'd23,
    TK_IF        = 5'd24,
    TK_ELSE      = 5'd25,
    TK_RETURN    = 5'd26
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [TOK_W-1:0]   start;
    logic [TOK_W-1:0]   length;
  } tok_t;

  // One queue entry: the tokens caused by one character, first in emission order.
  typedef struct packed {
    logic two;
    tok_t first;
    tok_t second;
  } step_rec_t;

endpackage
`default_nettype wire

[hw/rtl/script_lexer_tokenizer_core.sv]
// Streaming lexer: one source byte in, zero to two tokens (kind, start offset,
// length) out. The front end accepts one byte every cycle while the token queue
// has room; each byte updates the pending-token state in that same cycle. A
// byte that ends a pending word, number, '=' or '!' and also forms a token of
// its own yields two output transactions, the second marked by tlast; the
// output register sends one token per cycle, so the byte rate stays at one per
// cycle unless the output stalls or many bytes yield two tokens. The first
// token of a byte passes through the queue and then the output register. A zero
// byte flushes any pending token, emits EOF and restarts offsets at zero.
// Depends on slt_pkg, slt_front, slt_fifo and slt_back.
`default_nettype none
module script_lexer_tokenizer_core (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire logic [7:0]                       s_axis_tdata,  // [7:0] ch
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // [4:0] token_kind, [20:5] token_start, [36:21] token_length, rest zero
  output logic [slt_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
  output logic                                  m_axis_tlast   // last_of_run
);
  import slt_pkg::*;

  logic      q_full, q_push, q_pop, q_empty;
  step_rec_t q_rec, q_head;

  slt_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .ch       (s_axis_tdata),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_rec    (q_rec)
  );

  slt_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_rec (q_rec),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty)
  );

  slt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (q_head),
    .empty     (q_empty),
    .pop       (q_pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

endmodule
`default_nettype wire

[hw/rtl/slt_front.sv]
// Lexer front end: accepts characters, keeps the pending-token state and
// forms the tokens of each character. Depends on slt_pkg.
`default_nettype none
module slt_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [7:0]        ch,
  input  wire logic              q_full,
  output logic                   q_push,
  output slt_pkg::step_rec_t     q_rec
);
  import slt_pkg::*;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_WORD,
    MODE_NUM,
    MODE_ASSIGN,
    MODE_BANG
  } mode_t;

  mode_t                  mode, mode_next;
  logic [OFFSET_BITS-1:0] pos, pos_next;
  logic [OFFSET_BITS-1:0] pstart, pstart_next;
  logic [OFFSET_BITS-1:0] plen, plen_next;
  logic [KW_BITS-1:0]     prefix, prefix_next;
  logic                   kw_ok, kw_ok_next;

  logic                   accept;
  logic                   consumed;
  logic                   have_flush, have_new;
  tok_t                   flush_tok, new_tok;
  logic [OFFSET_BITS-1:0] pos_inc;
  logic [OFFSET_BITS-1:0] plen_inc;
  kind_t                  word_k;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == 8'h5F;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0D;
  endfunction

  function automatic kind_t single_kind(input logic [7:0] c);
    case (c)
      8'h2B:   return TK_PLUS;
      8'h2D:   return TK_MINUS;
      8'h2A:   return TK_ASTERISK;
      8'h2F:   return TK_SLASH;
      8'h3C:   return TK_LT;
      8'h3E:   return TK_GT;
      8'h2C:   return TK_COMMA;
      8'h3B:   return TK_SEMICOLON;
      8'h28:   return TK_LPAREN;
      8'h29:   return TK_RPAREN;
      8'h7B:   return TK_LBRACE;
      8'h7D:   return TK_RBRACE;
      default: return TK_ILLEGAL;
    endcase
  endfunction

  // Keyword text packed with the first character in the lowest byte.
  function automatic logic [KW_BITS-1:0] kw_text(input kind_t k);
    case (k)
      TK_FN:     return KW_BITS'(48'h6E66);
      TK_LET:    return KW_BITS'(48'h74656C);
      TK_TRUE:   return KW_BITS'(48'h65757274);
      TK_FALSE:  return KW_BITS'(48'h65736C6166);
      TK_IF:     return KW_BITS'(48'h6669);
      TK_ELSE:   return KW_BITS'(48'h65736C65);
      TK_RETURN: return KW_BITS'(48'h6E7275746572);
      default:   return '0;
    endcase
  endfunction

  function automatic logic [3:0] kw_len(input kind_t k);
    case (k)
      TK_FN, TK_IF:             return 4'd2;
      TK_LET:                   return 4'd3;
      TK_TRUE, TK_ELSE:         return 4'd4;
      TK_FALSE:                 return 4'd5;
      TK_RETURN:                return 4'd6;
      default:                  return 4'd0;
    endcase
  endfunction

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign pos_inc  = pos + 1'b1;
  assign plen_inc = (plen == {OFFSET_BITS{1'b1}}) ? plen : plen + 1'b1;

  always_comb begin
    word_k = TK_IDENT;
    if (kw_ok) begin
      for (int k = 20; k <= 26; k++) begin
        if (plen == OFFSET_BITS'(kw_len(kind_t'(k))) && prefix == kw_text(kind_t'(k))) begin
          word_k = kind_t'(k);
        end
      end
    end
  end

  always_comb begin
    mode_next   = mode;
    pos_next    = pos;
    pstart_next = pstart;
    plen_next   = plen;
    prefix_next = prefix;
    kw_ok_next  = kw_ok;
    consumed    = 1'b0;
    have_flush  = 1'b0;
    have_new    = 1'b0;
    flush_tok   = '{kind: TK_ILLEGAL, start: TOK_W'(pstart), length: TOK_W'(plen)};
    new_tok     = '{kind: TK_ILLEGAL, start: TOK_W'(pos), length: TOK_W'(1)};
    if (accept) begin
      pos_next = pos_inc;
      case (mode)
        MODE_WORD: begin
          if (is_letter(ch)) begin
            consumed = 1'b1;
            if (plen < OFFSET_BITS'(KEYWORD_CHARS)) begin
              for (int i = 0; i < KEYWORD_CHARS; i++) begin
                if (plen == OFFSET_BITS'(i)) begin
                  prefix_next[8*i +: 8] = ch;
                end
              end
            end else begin
              kw_ok_next = 1'b0;
            end
            plen_next = plen_inc;
          end else begin
            have_flush     = 1'b1;
            flush_tok.kind = word_k;
          end
        end
        MODE_NUM: begin
          if (is_digit(ch)) begin
            consumed  = 1'b1;
            plen_next = plen_inc;
          end else begin
            have_flush     = 1'b1;
            flush_tok.kind = TK_INT;
          end
        end
        MODE_ASSIGN, MODE_BANG: begin
          have_flush = 1'b1;
          if (ch == 8'h3D) begin
            consumed         = 1'b1;
            mode_next        = MODE_IDLE;
            flush_tok.kind   = (mode == MODE_ASSIGN) ? TK_EQ : TK_NOT_EQ;
            flush_tok.length = TOK_W'(2);
          end else begin
            flush_tok.kind   = (mode == MODE_ASSIGN) ? TK_ASSIGN : TK_BANG;
            flush_tok.length = TOK_W'(1);
          end
        end
        default: ;
      endcase

      if (!consumed) begin
        mode_next = MODE_IDLE;
        if (ch == 8'h00) begin
          // End of text: report EOF at this offset and start over from zero.
          have_new       = 1'b1;
          new_tok.kind   = TK_EOF;
          new_tok.length = '0;
          pos_next       = '0;
          pstart_next    = '0;
          plen_next      = '0;
          prefix_next    = '0;
          kw_ok_next     = 1'b1;
        end else if (is_space(ch)) begin
          mode_next = MODE_IDLE;
        end else if (is_letter(ch)) begin
          mode_next   = MODE_WORD;
          pstart_next = pos;
          plen_next   = OFFSET_BITS'(1);
          prefix_next = KW_BITS'(ch);
          kw_ok_next  = 1'b1;
        end else if (is_digit(ch)) begin
          mode_next   = MODE_NUM;
          pstart_next = pos;
          plen_next   = OFFSET_BITS'(1);
        end else if (ch == 8'h3D || ch == 8'h21) begin
          mode_next   = (ch == 8'h3D) ? MODE_ASSIGN : MODE_BANG;
          pstart_next = pos;
          plen_next   = OFFSET_BITS'(1);
        end else begin
          have_new     = 1'b1;
          new_tok.kind = single_kind(ch);
        end
      end
    end
  end

  always_comb begin
    q_push       = have_flush || have_new;
    q_rec.two    = have_flush && have_new;
    q_rec.first  = have_flush ? flush_tok : new_tok;
    q_rec.second = new_tok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= MODE_IDLE;
      pos    <= '0;
      pstart <= '0;
      plen   <= '0;
      prefix <= '0;
      kw_ok  <= 1'b1;
    end else begin
      mode   <= mode_next;
      pos    <= pos_next;
      pstart <= pstart_next;
      plen   <= plen_next;
      prefix <= prefix_next;
      kw_ok  <= kw_ok_next;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/slt_fifo.sv]
// Short queue of per-character token records between front and back end.
// Depends on slt_pkg and the assertion header.
`default_nettype none
`include "script_lexer_tokenizer_core_assert.svh"
module slt_fifo (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire slt_pkg::step_rec_t  push_rec,
  output logic                     full,
  input  wire logic                pop,
  output slt_pkg::step_rec_t       head,
  output logic                     empty
);
  import slt_pkg::*;

  step_rec_t             entries [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [FIFO_PTR_W:0]   count;

  assign full  = (count == (FIFO_PTR_W+1)'(FIFO_DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `SLT_ASSERT_IMPL(a_no_overflow, clk, rst, push, !full)
  `SLT_ASSERT_IMPL(a_no_underflow, clk, rst, pop, !empty)
  `SLT_ASSERT_IMPL(a_count_bound, clk, rst, 1'b1, count <= (FIFO_PTR_W+1)'(FIFO_DEPTH))

endmodule
`default_nettype wire

[hw/rtl/slt_back.sv]
// Lexer back end: drains queued records and sends one token per output
// transaction through a registered stream output. Depends on slt_pkg.
`default_nettype none
`include "script_lexer_tokenizer_core_assert.svh"
module slt_back (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire slt_pkg::step_rec_t           head,
  input  wire logic                         empty,
  output logic                              pop,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [slt_pkg::OUT_DATA_W-1:0]    out_data,
  output logic                              out_last
);
  import slt_pkg::*;

  logic beat;   // set while the second token of a pair is still owed
  logic load;
  tok_t sel_tok;
  logic sel_last;

  assign load     = !empty && (!out_valid || out_ready);
  assign sel_last = !head.two || beat;
  assign sel_tok  = beat ? head.second : head.first;
  assign pop      = load && sel_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      beat      <= 1'b0;
      out_last  <= 1'b0;
      out_data  <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        out_last  <= sel_last;
        out_data  <= OUT_DATA_W'({sel_tok.length, sel_tok.start, sel_tok.kind});
        beat      <= !sel_last;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `SLT_ASSERT_IMPL(a_pair_pending, clk, rst, beat, out_valid && !out_last)
  `SLT_ASSERT_NEXT(a_pair_follows, clk, rst, out_valid && out_ready && !out_last, out_valid)
  `SLT_ASSERT_IMPL(a_pop_on_last, clk, rst, pop, load && (!head.two || beat))

endmodule
`default_nettype wire
